@@ rtl/bshq_pkg.sv @@
// ============================================================================
// bshq_pkg
// Shared constants and types for the bitcrusher sample-hold quantizer.
// ============================================================================
`default_nettype none

package bshq_pkg;

  // sample width default, and the wide fixed-point format where 1.0 is 2^24
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned WET_FRAC        = 24;
  localparam int unsigned WET_W           = WET_FRAC + 3;

  localparam int unsigned PHASE_W   = 17;
  localparam int unsigned DEPTH_W   = 5;
  localparam int unsigned MIX_W     = 16;
  localparam int unsigned LFSR_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 17;

  localparam logic [PHASE_W-1:0] PHASE_ONE    = 17'h1_0000;
  localparam logic [DEPTH_W-1:0] DEPTH_BYPASS = 5'd16;
  localparam logic [DEPTH_W-1:0] DEPTH_MIN    = 5'd1;
  localparam logic [MIX_W-1:0]   MIX_ONE      = 16'h8000;
  localparam logic [LFSR_W-1:0]  LFSR_SEED    = 16'hACE1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_INC   = 2'd0,
    CFG_CRUSH_DEPTH = 2'd1,
    CFG_MIX_LEVEL   = 2'd2
  } cfg_reg_e;

  // clamped register values as the datapath sees them
  typedef struct packed {
    logic [PHASE_W-1:0] inc;
    logic [DEPTH_W-1:0] depth;
    logic               bypass;
    logic [MIX_W-1:0]   mix;
  } cfg_t;

endpackage : bshq_pkg

`default_nettype wire

@@ rtl/bitcrusher_sample_hold_quantize.sv @@
// ============================================================================
// bitcrusher_sample_hold_quantize
// Audio bitcrusher: sample-rate reduction by phase-driven hold, quantization
// with LFSR dither, and dry/wet mix with saturation.
// ============================================================================
// The block takes one sample per clock while not stalled and returns one
// mixed sample for each, in order. The four registers on the way are the
// front stage (phase accumulator, hold register and dither LFSR update at
// acceptance), the quantize stage, the product stage of the mix and the
// output register. Each stage holds its word under stall, so a new sample
// enters while a finished one waits at the output. Configuration takes effect
// on the next sample. The user must write it only while no sample is in flight,
// which the block does not enforce; there is no clearing pass after reset.
`default_nettype none

module bitcrusher_sample_hold_quantize #(
  parameter int unsigned SAMPLE_BITS = bshq_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [bshq_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [bshq_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]        dry_sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]        mixed_sample_o
);
  import bshq_pkg::*;

  function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] l);
    logic fb;
    fb = l[0] ^ l[2] ^ l[3] ^ l[5];
    return {fb, l[LFSR_W-1:1]};
  endfunction

  cfg_t                          cfg;
  logic [PHASE_W-1:0]            phase_q, phase_d;
  logic [PHASE_W-1:0]            phase_sum;
  logic signed [SAMPLE_BITS-1:0] held_q, held_d;
  logic [LFSR_W-1:0]             lfsr_q, lfsr_d;
  logic                          front_valid_q;
  logic signed [SAMPLE_BITS-1:0] front_dry_q;
  logic                          front_ready;
  logic                          accept;
  logic                          quant_ready;
  logic                          quant_valid;
  logic signed [SAMPLE_BITS-1:0] quant_dry;
  logic signed [WET_W-1:0]       quant_wet;
  logic                          mix_ready;
  logic                          wrap;

  bshq_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign front_ready = !front_valid_q || quant_ready;
  assign accept      = in_valid_i && front_ready;
  assign in_stall_o  = !front_ready;

  // phase stays below 1.0, so the sum fits without a carry out
  always_comb begin
    phase_sum = phase_q + cfg.inc;
    wrap      = phase_sum[PHASE_W-1];
    phase_d   = phase_q;
    held_d    = held_q;
    lfsr_d    = lfsr_q;
    if (accept) begin
      phase_d = {1'b0, phase_sum[PHASE_W-2:0]};
      if (wrap) begin
        held_d = dry_sample_i;
      end
      if (!cfg.bypass) begin
        lfsr_d = lfsr_next(lfsr_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= '0;
      held_q        <= '0;
      lfsr_q        <= LFSR_SEED;
      front_valid_q <= 1'b0;
    end else begin
      phase_q       <= phase_d;
      held_q        <= held_d;
      lfsr_q        <= lfsr_d;
      front_valid_q <= accept || (front_valid_q && !quant_ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      front_dry_q <= dry_sample_i;
    end
  end

  // hold and LFSR registers double as the front stage payload: they only
  // change when a new sample is accepted into that stage
  bshq_quant #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_quant (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (front_valid_q),
    .ready_o (quant_ready),
    .dry_i   (front_dry_q),
    .held_i  (held_q),
    .lfsr_i  (lfsr_q),
    .valid_o (quant_valid),
    .ready_i (mix_ready),
    .dry_o   (quant_dry),
    .wet_o   (quant_wet)
  );

  bshq_mix #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mix (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .valid_i        (quant_valid),
    .ready_o        (mix_ready),
    .dry_i          (quant_dry),
    .wet_i          (quant_wet),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .mixed_sample_o (mixed_sample_o)
  );

`ifndef SYNTH
  a_state_holds_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(phase_q) && $stable(held_q) && $stable(lfsr_q))
    else $error("crusher state changed without an accepted sample");

  a_lfsr_frozen_bypass : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && cfg.bypass |=> $stable(lfsr_q))
    else $error("dither LFSR advanced while quantization is bypassed");

  a_lfsr_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> lfsr_q != '0)
    else $error("dither LFSR locked at zero");

  a_phase_below_one : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !phase_q[PHASE_W-1])
    else $error("phase accumulator reached 1.0 after wrap");
`endif

endmodule : bitcrusher_sample_hold_quantize

`default_nettype wire

@@ rtl/bshq_cfg.sv @@
// ============================================================================
// bshq_cfg
// Configuration registers with range clamping applied on the read side.
// ============================================================================
`default_nettype none

module bshq_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bshq_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [bshq_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output bshq_pkg::cfg_t                    cfg_o
);
  import bshq_pkg::*;

  logic [PHASE_W-1:0] inc_q;
  logic [DEPTH_W-1:0] depth_q;
  logic [MIX_W-1:0]   mix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inc_q   <= PHASE_ONE;
      depth_q <= DEPTH_BYPASS;
      mix_q   <= MIX_ONE;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_PHASE_INC:   inc_q   <= cfg_data_i[PHASE_W-1:0];
        CFG_CRUSH_DEPTH: depth_q <= cfg_data_i[DEPTH_W-1:0];
        CFG_MIX_LEVEL:   mix_q   <= cfg_data_i[MIX_W-1:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  always_comb begin
    cfg_o.inc = (inc_q > PHASE_ONE) ? PHASE_ONE : inc_q;
    if (depth_q < DEPTH_MIN) begin
      cfg_o.depth = DEPTH_MIN;
    end else if (depth_q > DEPTH_BYPASS) begin
      cfg_o.depth = DEPTH_BYPASS;
    end else begin
      cfg_o.depth = depth_q;
    end
    cfg_o.bypass = (depth_q >= DEPTH_BYPASS);
    cfg_o.mix    = (mix_q > MIX_ONE) ? MIX_ONE : mix_q;
  end

endmodule : bshq_cfg

`default_nettype wire

@@ rtl/bshq_quant.sv @@
// ============================================================================
// bshq_quant
// Quantize: unless bypassed, rounds the held sample to the crush step + dither.
// ============================================================================
`default_nettype none

module bshq_quant #(
  parameter int unsigned SAMPLE_BITS = bshq_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  bshq_pkg::cfg_t                         cfg_i,
  input  logic                                   valid_i,
  output logic                                   ready_o,
  input  logic signed [SAMPLE_BITS-1:0]          dry_i,
  input  logic signed [SAMPLE_BITS-1:0]          held_i,
  input  logic [bshq_pkg::LFSR_W-1:0]            lfsr_i,
  output logic                                   valid_o,
  input  logic                                   ready_i,
  output logic signed [SAMPLE_BITS-1:0]          dry_o,
  output logic signed [bshq_pkg::WET_W-1:0]      wet_o
);
  import bshq_pkg::*;

  localparam int unsigned UP = WET_FRAC + 1 - SAMPLE_BITS;

  logic                          valid_q;
  logic signed [SAMPLE_BITS-1:0] dry_q;
  logic signed [WET_W-1:0]       wet_q;
  logic signed [WET_W-1:0]       wet_d;
  logic signed [WET_W-1:0]       wet_full;
  logic signed [WET_W-1:0]       rounded;
  logic signed [WET_W-1:0]       quant;
  logic signed [WET_W-1:0]       dither;
  logic [WET_W-1:0]              step_mask;
  logic [DEPTH_W-1:0]            k;
  logic [WET_FRAC-1:0]           dith_raw;
  logic                          load;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    wet_full  = WET_W'(held_i) <<< UP;
    k         = DEPTH_W'(WET_FRAC + 1) - cfg_i.depth;
    // round half up to a multiple of 2^k
    rounded   = wet_full + $signed(WET_W'(1) << (k - DEPTH_W'(1)));
    step_mask = {WET_W{1'b1}} << k;
    quant     = rounded & $signed(step_mask);
    dith_raw  = {lfsr_i, 8'h00} >> cfg_i.depth;
    dither    = $signed(WET_W'(dith_raw))
              - $signed(WET_W'(1) << (DEPTH_W'(WET_FRAC - 1) - cfg_i.depth));
    wet_d     = cfg_i.bypass ? wet_full : (quant + dither);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= load || (valid_q && !ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      dry_q <= dry_i;
      wet_q <= wet_d;
    end
  end

  assign valid_o = valid_q;
  assign dry_o   = dry_q;
  assign wet_o   = wet_q;

endmodule : bshq_quant

`default_nettype wire

@@ rtl/bshq_mix.sv @@
// ============================================================================
// bshq_mix
// Dry/wet blend: product stage, then sum, round and saturate into the output
// register.
// ============================================================================
`default_nettype none

module bshq_mix #(
  parameter int unsigned SAMPLE_BITS = bshq_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  bshq_pkg::cfg_t                         cfg_i,
  input  logic                                   valid_i,
  output logic                                   ready_o,
  input  logic signed [SAMPLE_BITS-1:0]          dry_i,
  input  logic signed [bshq_pkg::WET_W-1:0]      wet_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]          mixed_sample_o
);
  import bshq_pkg::*;

  localparam int unsigned UP     = WET_FRAC + 1 - SAMPLE_BITS;
  localparam int unsigned DOWN   = WET_FRAC + 16 - SAMPLE_BITS;
  localparam int unsigned PD_W   = SAMPLE_BITS + MIX_W + 1;
  localparam int unsigned PW_W   = WET_W + MIX_W + 1;
  localparam int unsigned TOT_W  = PW_W + 1;
  localparam logic signed [TOT_W-1:0] SMAX = TOT_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [TOT_W-1:0] SMIN = -SMAX - TOT_W'(1);

  logic                          prod_valid_q;
  logic signed [PD_W-1:0]        p_dry_q;
  logic signed [PW_W-1:0]        p_wet_q;
  logic signed [PD_W-1:0]        p_dry_d;
  logic signed [PW_W-1:0]        p_wet_d;
  logic [MIX_W-1:0]              dry_gain;
  logic                          prod_ready;
  logic                          prod_load;
  logic                          out_ready;
  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] mixed_q;
  logic signed [TOT_W-1:0]       total;
  logic signed [TOT_W-1:0]       scaled;
  logic signed [TOT_W-1:0]       sat;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign prod_ready = !prod_valid_q || out_ready;
  assign prod_load  = valid_i && prod_ready;
  assign ready_o    = prod_ready;

  always_comb begin
    dry_gain = MIX_ONE - cfg_i.mix;
    p_dry_d  = $signed(dry_i) * $signed({1'b0, dry_gain});
    p_wet_d  = wet_i * $signed({1'b0, cfg_i.mix});
  end

  always_comb begin
    total  = (TOT_W'(p_dry_q) <<< UP) + TOT_W'(p_wet_q);
    // round half up, then saturate to the sample range
    scaled = (total + (TOT_W'(1) <<< (DOWN - 1))) >>> DOWN;
    if (scaled > SMAX) begin
      sat = SMAX;
    end else if (scaled < SMIN) begin
      sat = SMIN;
    end else begin
      sat = scaled;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      prod_valid_q <= prod_load || (prod_valid_q && !out_ready);
      if (out_ready) begin
        out_valid_q <= prod_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod_load) begin
      p_dry_q <= p_dry_d;
      p_wet_q <= p_wet_d;
    end
    if (out_ready && prod_valid_q) begin
      mixed_q <= sat[SAMPLE_BITS-1:0];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign mixed_sample_o = mixed_q;

endmodule : bshq_mix

`default_nettype wire
